// ===== src/pafk_pkg.sv =====
// ============================================================================
// pafk_pkg
// Shared constants, types and elaboration-time functions for the planar arm
// forward kinematics block: field widths, register reset values, the sine
// table builder and the sequencer state type.
// ============================================================================
package pafk_pkg;

    // Default parameter values
    localparam int NUM_LINKS_DEFAULT          = 3;
    localparam int TRIG_FRACTION_BITS_DEFAULT = 14;

    // Field widths
    localparam int FIELD_LINKS = 3;   // joints and links carried by the word
    localparam int ANGLE_W     = 10;  // signed joint angle, whole degrees
    localparam int LINK_SEL_W  = 2;   // link number field
    localparam int LINK_W      = 10;  // link length register
    localparam int POS_W       = 27;  // result position
    localparam int CFG_INDEX_W = 2;   // register index on the config port
    localparam int DEG_W       = 9;   // reduced angle 0..359
    localparam int QUAD_DEG_W  = 7;   // first quadrant angle 0..90

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_LINK_LENGTH_1 = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LINK_LENGTH_2 = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LINK_LENGTH_3 = 2'd2;

    // Link length values after reset
    localparam logic [LINK_W-1:0] LINK_RESET [FIELD_LINKS] = '{10'd0, 10'd50, 10'd50};

    // Sine table: 0..90 degrees, wide enough for up to 20 fraction bits
    localparam int SINE_ROM_W     = 21;
    localparam int SINE_ROM_DEPTH = 91;
    typedef logic [SINE_ROM_W-1:0] sine_rom_t [SINE_ROM_DEPTH];

    // Q.30 series constants
    localparam logic [63:0] Q30_ONE = 64'd1073741824;
    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] SERIES_DENOM [8] = '{
        64'd272, 64'd210, 64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6
    };

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_LOOK_COS,
        ST_MUL_COS,
        ST_MUL_SIN,
        ST_ACC_SIN,
        ST_DONE
    } fk_state_t;

    // Q.30 sine of a first quadrant angle: odd series to x^17, Horner form,
    // every product and quotient truncated
    function automatic logic [63:0] sin_q30(input logic [QUAD_DEG_W-1:0] deg);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        x  = (64'(deg) * PI_Q30 + 64'd90) / 64'd180;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        for (int n = 0; n < 8; n++) begin
            t = Q30_ONE - ((x2 * t) >> 30) / SERIES_DENOM[n];
        end
        return (x * t) >> 30;
    endfunction

    // Table of sin(0..90 deg), rounded half up to frac_bits fraction bits
    function automatic sine_rom_t build_sine_rom(input int frac_bits);
        sine_rom_t   rom;
        logic [63:0] v;
        for (int d = 0; d < SINE_ROM_DEPTH; d++) begin
            v      = sin_q30(QUAD_DEG_W'(d));
            v      = (v + (64'd1 << (29 - frac_bits))) >> (30 - frac_bits);
            rom[d] = SINE_ROM_W'(v);
        end
        return rom;
    endfunction

endpackage

// ===== src/pafk_if.sv =====
// ============================================================================
// pafk_if
// Valid/ready channels of the planar arm forward kinematics block: the joint
// request word and the position response word.
// ============================================================================
interface pafk_in_if;
    import pafk_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] joint_angle_1;
    logic signed [ANGLE_W-1:0] joint_angle_2;
    logic signed [ANGLE_W-1:0] joint_angle_3;
    logic [LINK_SEL_W-1:0]     first_link;
    logic [LINK_SEL_W-1:0]     last_link;

    modport source (
        output valid, joint_angle_1, joint_angle_2, joint_angle_3,
               first_link, last_link,
        input  ready
    );

    modport sink (
        input  valid, joint_angle_1, joint_angle_2, joint_angle_3,
               first_link, last_link,
        output ready
    );
endinterface

interface pafk_out_if;
    import pafk_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;

    modport source (
        output valid, pos_x, pos_y,
        input  ready
    );

    modport sink (
        input  valid, pos_x, pos_y,
        output ready
    );
endinterface

// ===== src/pafk_sine.sv =====
// ============================================================================
// pafk_sine
// Registered sine lookup for a whole angle of 0..359 degrees: folds the angle
// onto the first quadrant, reads the constant table and restores the sign.
// The result is registered and appears in the cycle after the angle.
// ============================================================================
module pafk_sine #(
    parameter int TRIG_FRACTION_BITS = pafk_pkg::TRIG_FRACTION_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic [pafk_pkg::DEG_W-1:0]        angle,
    output logic signed [TRIG_FRACTION_BITS+1:0] trig_value
);
    import pafk_pkg::*;

    localparam int TRIG_W = TRIG_FRACTION_BITS + 2;
    localparam sine_rom_t SINE_ROM = build_sine_rom(TRIG_FRACTION_BITS);

    logic [QUAD_DEG_W-1:0]      quad_deg;
    logic                       negate;
    logic [TRIG_FRACTION_BITS:0] magnitude;
    logic signed [TRIG_W-1:0]   mag_ext;
    logic signed [TRIG_W-1:0]   trig_next;
    logic signed [TRIG_W-1:0]   trig_reg;

    // Quadrant fold
    always_comb
    begin
        if (angle <= DEG_W'(90)) begin
            quad_deg = QUAD_DEG_W'(angle);
            negate   = 1'b0;
        end else if (angle <= DEG_W'(180)) begin
            quad_deg = QUAD_DEG_W'(DEG_W'(180) - angle);
            negate   = 1'b0;
        end else if (angle <= DEG_W'(270)) begin
            quad_deg = QUAD_DEG_W'(angle - DEG_W'(180));
            negate   = 1'b1;
        end else begin
            quad_deg = QUAD_DEG_W'(DEG_W'(360) - angle);
            negate   = 1'b1;
        end
    end

    // Table read and sign
    assign magnitude = SINE_ROM[quad_deg][TRIG_FRACTION_BITS:0];
    assign mag_ext   = signed'({1'b0, magnitude});
    assign trig_next = negate ? -mag_ext : mag_ext;

    always_ff @(posedge clk)
    begin
        trig_reg <= trig_next;
    end

    assign trig_value = trig_reg;

endmodule

// ===== src/planar_arm_forward_kinematics_top.sv =====
// ============================================================================
// planar_arm_forward_kinematics_top
// Forward kinematics of a sub-chain of a three-link planar arm: sums
// length * cos and length * sin of the accumulated joint angle over the
// chosen links, one shared multiplier and one sine table under a sequencer.
// ============================================================================
//
//  Channel   Dir  Handshake            Word
//  -------   ---  -------------------  -----------------------------------------
//  req       in   valid/ready          joint_angle_1..3, first_link, last_link
//  rsp       out  valid/ready          pos_x, pos_y
//  cfg       in   cfg_we               cfg_index, cfg_data (link lengths)
//
//  Each link takes two table reads and two passes through the single
//  length-by-sine multiplier. If first_link is not below last_link, the
//  loop is skipped and x carries the first link's length, y zero.
//  One request is in flight at a time; req.ready is high only when idle.
//  The response register lets a new request start while a word waits on rsp.
//  Reset clears the sequencer and loads the link lengths 0, 50, 50.
//
module planar_arm_forward_kinematics_top #(
    parameter int NUM_LINKS          = pafk_pkg::NUM_LINKS_DEFAULT,
    parameter int TRIG_FRACTION_BITS = pafk_pkg::TRIG_FRACTION_BITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [pafk_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pafk_pkg::LINK_W-1:0]      cfg_data,
    pafk_in_if.sink                          req,
    pafk_out_if.source                       rsp
);
    import pafk_pkg::*;

    localparam int LINK_COUNT = (NUM_LINKS < FIELD_LINKS) ? NUM_LINKS : FIELD_LINKS;
    localparam int LINK_IDX_W = $clog2(LINK_COUNT);
    localparam int TRIG_W     = TRIG_FRACTION_BITS + 2;
    localparam int PROD_W     = LINK_W + 1 + TRIG_W;
    localparam int ACC_W      = TRIG_FRACTION_BITS + 17;
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((2 ** (POS_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

    fk_state_t state_reg, state_next;

    logic [LINK_W-1:0]         link_len_reg [LINK_COUNT];
    logic signed [ANGLE_W-1:0] angle_reg    [LINK_COUNT];
    logic signed [ANGLE_W-1:0] req_angle    [FIELD_LINKS];
    logic [LINK_IDX_W-1:0]     first_reg, last_reg, k_reg;
    logic [LINK_IDX_W-1:0]     first_dec, last_dec;
    logic [DEG_W-1:0]          phi_reg, phi_next, cos_angle, sine_angle;
    logic signed [ACC_W-1:0]   acc_x_reg, acc_y_reg;
    logic signed [PROD_W-1:0]  prod_reg, mult_out;
    logic signed [LINK_W:0]    len_ext;
    logic signed [TRIG_W-1:0]  trig_value;
    logic signed [POS_W-1:0]   pos_x_reg, pos_y_reg;
    logic                      out_valid_reg;
    logic                      accept, out_load;

    // Link number to table index: zero reads as one, above count as last
    function automatic logic [LINK_IDX_W-1:0] link_index(input logic [LINK_SEL_W-1:0] raw);
        logic [LINK_SEL_W-1:0] v;
        v = (raw == '0) ? LINK_SEL_W'(1) : raw;
        if (v > LINK_SEL_W'(LINK_COUNT)) begin
            v = LINK_SEL_W'(LINK_COUNT);
        end
        return LINK_IDX_W'(v - LINK_SEL_W'(1));
    endfunction

    // Clamp an accumulator to the response width
    function automatic logic signed [POS_W-1:0] saturate(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] c;
        c = v;
        if (c > SAT_HI) begin
            c = SAT_HI;
        end
        if (c < SAT_LO) begin
            c = SAT_LO;
        end
        return c[POS_W-1:0];
    endfunction

    assign req_angle[0] = req.joint_angle_1;
    assign req_angle[1] = req.joint_angle_2;
    assign req_angle[2] = req.joint_angle_3;
    assign first_dec    = link_index(req.first_link);
    assign last_dec     = link_index(req.last_link);

    assign accept   = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || rsp.ready);

    // Next accumulated angle, reduced to 0..359
    always_comb
    begin
        logic signed [ANGLE_W:0] t;
        t = signed'({2'b00, phi_reg}) + {angle_reg[k_reg][ANGLE_W-1], angle_reg[k_reg]};
        if (t < 0) begin
            t = t + (ANGLE_W+1)'(360);
        end
        if (t < 0) begin
            t = t + (ANGLE_W+1)'(360);
        end
        if (t >= (ANGLE_W+1)'(360)) begin
            t = t - (ANGLE_W+1)'(360);
        end
        if (t >= (ANGLE_W+1)'(360)) begin
            t = t - (ANGLE_W+1)'(360);
        end
        phi_next = DEG_W'(t);
    end

    // Cosine as sine of the angle plus a quarter turn
    assign cos_angle  = (phi_reg >= DEG_W'(270)) ? phi_reg - DEG_W'(270)
                                                 : phi_reg + DEG_W'(90);
    assign sine_angle = (state_reg == ST_LOOK_COS) ? cos_angle : phi_reg;

    pafk_sine #(
        .TRIG_FRACTION_BITS (TRIG_FRACTION_BITS)
    ) u_sine (
        .clk        (clk),
        .angle      (sine_angle),
        .trig_value (trig_value)
    );

    // Shared length-by-trig multiplier
    assign len_ext  = signed'({1'b0, link_len_reg[k_reg]});
    assign mult_out = len_ext * trig_value;

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (accept) state_next = ST_START;
            ST_START:    state_next = (first_reg >= last_reg) ? ST_DONE : ST_LOOK_COS;
            ST_LOOK_COS: state_next = ST_MUL_COS;
            ST_MUL_COS:  state_next = ST_MUL_SIN;
            ST_MUL_SIN:  state_next = ST_ACC_SIN;
            ST_ACC_SIN:  state_next = (k_reg == last_reg) ? ST_DONE : ST_LOOK_COS;
            ST_DONE:     if (out_load) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Link length registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < LINK_COUNT; i++) begin
                link_len_reg[i] <= LINK_RESET[i];
            end
        end else if (cfg_we && (cfg_index < CFG_INDEX_W'(LINK_COUNT))) begin
            link_len_reg[cfg_index[LINK_IDX_W-1:0]] <= cfg_data;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept) begin
                    for (int i = 0; i < LINK_COUNT; i++) begin
                        angle_reg[i] <= req_angle[i];
                    end
                    first_reg <= first_dec;
                    last_reg  <= last_dec;
                end
            end
            ST_START:
            begin
                k_reg   <= first_reg;
                phi_reg <= '0;
                if (first_reg >= last_reg) begin
                    acc_x_reg <= signed'({{(ACC_W-LINK_W-TRIG_FRACTION_BITS){1'b0}},
                                          link_len_reg[first_reg],
                                          {TRIG_FRACTION_BITS{1'b0}}});
                end else begin
                    acc_x_reg <= '0;
                end
                acc_y_reg <= '0;
            end
            ST_MUL_COS:
            begin
                prod_reg <= mult_out;
            end
            ST_MUL_SIN:
            begin
                acc_x_reg <= acc_x_reg + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
                prod_reg  <= mult_out;
            end
            ST_ACC_SIN:
            begin
                acc_y_reg <= acc_y_reg + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
                phi_reg   <= phi_next;
                k_reg     <= k_reg + LINK_IDX_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    // Response register
    always_ff @(posedge clk)
    begin
        if (out_load) begin
            pos_x_reg <= saturate(acc_x_reg);
            pos_y_reg <= saturate(acc_y_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (rsp.ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.pos_x = pos_x_reg;
    assign rsp.pos_y = pos_y_reg;

endmodule
